// ----- rtl/fwao_pkg.sv -----
// Shared types and constants of the force-weighted axis orientation block.
// Used by fwao_ctrl, fwao_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package fwao_pkg;

  typedef struct packed {
    logic signed [31:0] edge_dx;
    logic signed [31:0] edge_dy;
    logic signed [31:0] force_a;
    logic signed [31:0] force_b;
    logic signed [31:0] force_c;
    logic signed [31:0] force_d;
    logic               cell_active;
    logic               last_wall;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } out_word_t;

  // Register indexes of the configuration port.
  localparam logic CFG_PERP   = 1'b0;
  localparam logic CFG_NTERMS = 1'b1;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] WALL_DIV_STEPS = 6'd31;
  localparam logic [CNT_W-1:0] HALF_DIV_STEPS = 6'd29;
  localparam logic [CNT_W-1:0] SUM_ROOT_STEPS = 6'd32;
  localparam logic [CNT_W-1:0] Q_ROOT_STEPS   = 6'd15;
  localparam int SUM_ROOT_BIT = 62;
  localparam int Q_ROOT_BIT   = 28;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_NORM,
    OP_SQA,
    OP_SQB,
    OP_CROSS,
    OP_DIV_WALL,
    OP_DIV_HALF,
    OP_DIV_STEP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMBINE,
    OP_ACC,
    OP_HLOAD,
    OP_ROOT_SUM,
    OP_ROOT_Q,
    OP_ROOT_STEP,
    OP_SAVE_X,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel;   // selects the sine lane where an operation has two
  } dp_cmd_t;

  typedef struct packed {
    logic in_active;
    logic in_last;
    logic last;
    logic norm_w_ok;
    logic norm_h_ok;
    logic cnt_zero;
    logic root_zero;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/force_weighted_axis_orientation.sv -----
// Top level of the force-weighted axis orientation block.
// Instantiates fwao_ctrl and fwao_dp; uses fwao_pkg types.
//
// Usage: wall words enter on in_valid_i / in_stall_o / in_data_i; a word is
// taken when valid is high and stall is low. Results leave on out_valid_o /
// out_stall_i / out_data_o, held steady while the receiver stalls. The
// configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is
// always ready; index 0 selects the perpendicular output, index 1 the number
// of force terms summed.
// Flow: one wall word at a time. An active wall shifts its edge below 2^15,
// then runs the 31-step two-lane divider. An active last wall adds the
// half-angle evaluation: the sums are shifted below 2^31, then come the
// 32-step root, the 29-step divider and two 15-step roots; it is shorter when
// both sums are zero. An inactive word is not evaluated. A result waits in the
// output register; the next wall word is taken while it waits, and only a
// second result waits for the first to be taken. Reset clears the sums and
// the output valid and sets the configuration to its defaults.
`timescale 1ns / 1ps
`default_nettype none
module force_weighted_axis_orientation #(
  parameter int MAX_FORCE_TERMS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire fwao_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fwao_pkg::out_word_t     out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [2:0]         cfg_data_i
);

  fwao_pkg::dp_cmd_t    cmd;
  fwao_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;

  fwao_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fwao_dp #(
    .MAX_FORCE_TERMS (MAX_FORCE_TERMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- rtl/fwao_dp.sv -----
// Datapath: operand registers, shared multiplier, two-lane divider, square root
// iteration, sum accumulators and output register. Depends on fwao_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fwao_dp #(
  parameter int MAX_FORCE_TERMS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fwao_pkg::in_word_t in_data_i,
  input  wire fwao_pkg::dp_cmd_t  cmd_i,
  output fwao_pkg::dp_status_t    st_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [2:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fwao_pkg::out_word_t     out_data_o
);

  localparam int FW  = 32 + $clog2(MAX_FORCE_TERMS);
  localparam int FLO = 17;
  localparam int FHI = FW - FLO;

  logic [63:0] na_q, nb_q;
  logic [61:0] sq_a_q, sq_b_q;
  logic [29:0] cross_q;
  logic [35:0] rem0_q, rem1_q;
  logic [33:0] div_q;
  logic [30:0] qx_q, qy_q;
  logic [fwao_pkg::CNT_W-1:0] cnt_q;
  logic [63:0] v_q, r_q, bit_q;
  logic [FW-1:0] fmag_q;
  logic fneg_q, last_q, wsneg_q, wcneg_q, hcneg_q, hsneg_q, rz_q;
  logic [47:0] plo_q;
  logic [FHI+30:0] phi_q;
  logic [63:0] tc_q, ts_q, cos_q, sin_q;
  logic [15:0] xres_q;
  fwao_pkg::out_word_t out_q;
  logic out_valid_q, perp_q;
  logic [2:0] nterms_q;

  // Sum of the selected force terms.
  logic signed [31:0] frc [4];
  logic signed [FW-1:0] fsum;
  logic [FW-1:0] fmag;
  logic [2:0] nt;
  assign frc[0] = in_data_i.force_a;
  assign frc[1] = in_data_i.force_b;
  assign frc[2] = in_data_i.force_c;
  assign frc[3] = in_data_i.force_d;
  assign nt = (nterms_q > 3'(MAX_FORCE_TERMS)) ? 3'(MAX_FORCE_TERMS) : nterms_q;
  always_comb begin
    fsum = '0;
    for (int j = 0; j < MAX_FORCE_TERMS; j++) begin
      if (3'(j) < nt) fsum = fsum + FW'(frc[j]);
    end
    fmag = fsum[FW-1] ? FW'(-fsum) : FW'(fsum);
  end

  // Shared multiplier.
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [30:0] mt;
  assign mt = cmd_i.sel ? qy_q : qx_q;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      fwao_pkg::OP_SQA:    begin ma = na_q[31:0]; mb = na_q[31:0]; end
      fwao_pkg::OP_SQB:    begin ma = nb_q[31:0]; mb = nb_q[31:0]; end
      fwao_pkg::OP_CROSS:  begin ma = na_q[31:0]; mb = nb_q[31:0]; end
      fwao_pkg::OP_MUL_LO: begin ma = 32'(fmag_q[FLO-1:0]); mb = 32'(mt); end
      fwao_pkg::OP_MUL_HI: begin ma = 32'(fmag_q[FW-1:FLO]); mb = 32'(mt); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  // Wall trig operands.
  logic [30:0] l2;
  logic        wcneg;
  assign l2    = 31'(sq_a_q[29:0]) + 31'(sq_b_q[29:0]);
  assign wcneg = sq_b_q[29:0] > sq_a_q[29:0];

  // Divider step on both lanes.
  logic ge0, ge1;
  logic [35:0] nr0, nr1;
  assign ge0 = rem0_q >= 36'(div_q);
  assign ge1 = rem1_q >= 36'(div_q);
  assign nr0 = ge0 ? rem0_q - 36'(div_q) : rem0_q;
  assign nr1 = ge1 ? rem1_q - 36'(div_q) : rem1_q;

  // Half-angle operands.
  logic [31:0] rroot;
  logic [32:0] pcv, mcv;
  assign rroot = r_q[31:0];
  assign pcv = hcneg_q ? 33'(rroot) - 33'(na_q[30:0]) : 33'(rroot) + 33'(na_q[30:0]);
  assign mcv = hcneg_q ? 33'(rroot) + 33'(na_q[30:0]) : 33'(rroot) - 33'(na_q[30:0]);

  logic [63:0] tr;
  assign tr = r_q + bit_q;

  logic [FW+30:0] full;
  logic [63:0] term;
  assign full = {phi_q, {FLO{1'b0}}} + (FW+31)'(plo_q);
  assign term = 64'(full >> 30);

  logic [63:0] cmag, smag;
  assign cmag = cos_q[63] ? -cos_q : cos_q;
  assign smag = sin_q[63] ? -sin_q : sin_q;

  logic signed [15:0] xv, yv;
  always_comb begin
    xv = signed'(xres_q);
    yv = hsneg_q ? -signed'(r_q[15:0]) : signed'(r_q[15:0]);
    if (rz_q) begin
      xv = fwao_pkg::ONE_Q14;
      yv = '0;
    end
  end

  logic cneg_t, sneg_t;
  assign cneg_t = fneg_q ^ wcneg_q;
  assign sneg_t = fneg_q ^ wsneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cos_q       <= '0;
      sin_q       <= '0;
      perp_q      <= 1'b0;
      nterms_q    <= 3'd1;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == fwao_pkg::CFG_PERP) perp_q <= cfg_data_i[0];
        if (cfg_index_i == fwao_pkg::CFG_NTERMS) nterms_q <= cfg_data_i;
      end
      if (cmd_i.op == fwao_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        fwao_pkg::OP_ACC: begin
          cos_q <= cos_q + (cneg_t ? ~tc_q : tc_q) + 64'(cneg_t);
          sin_q <= sin_q + (sneg_t ? ~ts_q : ts_q) + 64'(sneg_t);
        end
        fwao_pkg::OP_HLOAD, fwao_pkg::OP_CLEAR: begin
          cos_q <= '0;
          sin_q <= '0;
        end
        default: ;
      endcase
      case (cmd_i.op)
        fwao_pkg::OP_DIV_WALL: cnt_q <= fwao_pkg::WALL_DIV_STEPS;
        fwao_pkg::OP_DIV_HALF: cnt_q <= fwao_pkg::HALF_DIV_STEPS;
        fwao_pkg::OP_ROOT_SUM: cnt_q <= fwao_pkg::SUM_ROOT_STEPS;
        fwao_pkg::OP_ROOT_Q:   cnt_q <= fwao_pkg::Q_ROOT_STEPS;
        fwao_pkg::OP_DIV_STEP, fwao_pkg::OP_ROOT_STEP: cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fwao_pkg::OP_LOAD: begin
        na_q    <= {32'd0, in_data_i.edge_dx[31] ? 32'(-in_data_i.edge_dx)
                                                 : 32'(in_data_i.edge_dx)};
        nb_q    <= {32'd0, in_data_i.edge_dy[31] ? 32'(-in_data_i.edge_dy)
                                                 : 32'(in_data_i.edge_dy)};
        wsneg_q <= in_data_i.edge_dx[31] ^ in_data_i.edge_dy[31];
        fmag_q  <= fmag;
        fneg_q  <= fsum[FW-1];
        last_q  <= in_data_i.last_wall;
      end
      fwao_pkg::OP_NORM: begin
        na_q <= na_q >> 1;
        nb_q <= nb_q >> 1;
      end
      fwao_pkg::OP_SQA:   sq_a_q  <= prod[61:0];
      fwao_pkg::OP_SQB:   sq_b_q  <= prod[61:0];
      fwao_pkg::OP_CROSS: cross_q <= prod[29:0];
      fwao_pkg::OP_DIV_WALL: begin
        wcneg_q <= wcneg;
        qx_q    <= '0;
        qy_q    <= '0;
        if (l2 == '0) begin
          // A zero-length wall counts as angle zero: quotients 1.0 and 0.
          div_q  <= 34'd1;
          rem0_q <= 36'd1;
          rem1_q <= '0;
        end else begin
          div_q  <= 34'(l2);
          rem0_q <= wcneg ? 36'(sq_b_q[29:0] - sq_a_q[29:0])
                          : 36'(sq_a_q[29:0] - sq_b_q[29:0]);
          rem1_q <= 36'({cross_q, 1'b0});
        end
      end
      fwao_pkg::OP_DIV_HALF: begin
        rz_q   <= rroot == '0;
        div_q  <= 34'({rroot, 1'b0});
        rem0_q <= 36'(pcv);
        rem1_q <= 36'(mcv);
        qx_q   <= '0;
        qy_q   <= '0;
      end
      fwao_pkg::OP_DIV_STEP: begin
        rem0_q <= {nr0[34:0], 1'b0};
        rem1_q <= {nr1[34:0], 1'b0};
        qx_q   <= {qx_q[29:0], ge0};
        qy_q   <= {qy_q[29:0], ge1};
      end
      fwao_pkg::OP_MUL_LO: plo_q <= prod[47:0];
      fwao_pkg::OP_MUL_HI: phi_q <= prod[FHI+30:0];
      fwao_pkg::OP_COMBINE: begin
        if (cmd_i.sel) ts_q <= term;
        else tc_q <= term;
      end
      fwao_pkg::OP_HLOAD: begin
        na_q    <= cmag;
        nb_q    <= smag;
        hcneg_q <= cos_q[63];
        hsneg_q <= sin_q[63];
      end
      fwao_pkg::OP_ROOT_SUM: begin
        v_q   <= 64'(sq_a_q) + 64'(sq_b_q);
        r_q   <= '0;
        bit_q <= 64'(1) << fwao_pkg::SUM_ROOT_BIT;
      end
      fwao_pkg::OP_ROOT_Q: begin
        v_q   <= 64'(cmd_i.sel ? qy_q : qx_q);
        r_q   <= '0;
        bit_q <= 64'(1) << fwao_pkg::Q_ROOT_BIT;
      end
      fwao_pkg::OP_ROOT_STEP: begin
        if (v_q >= tr) begin
          v_q <= v_q - tr;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      fwao_pkg::OP_SAVE_X: xres_q <= r_q[15:0];
      fwao_pkg::OP_EMIT: begin
        if (perp_q) begin
          out_q.dir_x <= -yv;
          out_q.dir_y <= xv;
        end else begin
          out_q.dir_x <= xv;
          out_q.dir_y <= yv;
        end
      end
      default: ;
    endcase
  end

  assign st_o.in_active = in_data_i.cell_active;
  assign st_o.in_last   = in_data_i.last_wall;
  assign st_o.last      = last_q;
  assign st_o.norm_w_ok = (na_q[63:15] | nb_q[63:15]) == '0;
  assign st_o.norm_h_ok = (na_q[63:31] | nb_q[63:31]) == '0;
  assign st_o.cnt_zero  = cnt_q == '0;
  assign st_o.root_zero = rroot == '0;
  assign st_o.out_full  = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == fwao_pkg::OP_EMIT |-> !out_valid_q)
    else $error("result written over a word not yet taken");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == fwao_pkg::OP_DIV_STEP || cmd_i.op == fwao_pkg::OP_ROOT_STEP)
      |-> cnt_q != '0)
    else $error("iteration step issued past its count");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == fwao_pkg::OP_DIV_STEP |->
      rem0_q < {1'b0, div_q, 1'b0} && rem1_q < {1'b0, div_q, 1'b0})
    else $error("divider remainder out of range");
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.dir_x <= fwao_pkg::ONE_Q14 && out_q.dir_x >= -fwao_pkg::ONE_Q14
      && out_q.dir_y <= fwao_pkg::ONE_Q14 && out_q.dir_y >= -fwao_pkg::ONE_Q14)
    else $error("direction component exceeds one");

endmodule
`default_nettype wire

// ----- rtl/fwao_ctrl.sv -----
// Sequencer of the orientation block: steps the datapath through wall trig,
// force weighting, accumulation and the half-angle evaluation. Uses fwao_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fwao_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire fwao_pkg::dp_status_t st_i,
  output fwao_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_WNORM, S_WSQA, S_WSQB, S_WCROSS, S_WDINIT, S_WDIV,
    S_CLO, S_CHI, S_CCMB, S_SLO, S_SHI, S_SCMB, S_ACC,
    S_HLOAD, S_HNORM, S_HSQA, S_HSQB, S_HRINIT, S_HROOT, S_HDINIT, S_HDIV,
    S_XRINIT, S_XROOT, S_XSAVE, S_YRINIT, S_YROOT, S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = fwao_pkg::OP_NONE;
    cmd_o.sel  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (st_i.in_active) begin
            cmd_o.op = fwao_pkg::OP_LOAD;
            state_d  = S_WNORM;
          end else if (st_i.in_last) begin
            cmd_o.op = fwao_pkg::OP_CLEAR;
          end
        end
      end
      S_WNORM: begin
        if (st_i.norm_w_ok) begin
          cmd_o.op = fwao_pkg::OP_SQA;
          state_d  = S_WSQB;
        end else begin
          cmd_o.op = fwao_pkg::OP_NORM;
        end
      end
      S_WSQA:   begin cmd_o.op = fwao_pkg::OP_SQA; state_d = S_WSQB; end
      S_WSQB:   begin cmd_o.op = fwao_pkg::OP_SQB; state_d = S_WCROSS; end
      S_WCROSS: begin cmd_o.op = fwao_pkg::OP_CROSS; state_d = S_WDINIT; end
      S_WDINIT: begin cmd_o.op = fwao_pkg::OP_DIV_WALL; state_d = S_WDIV; end
      S_WDIV: begin
        if (st_i.cnt_zero) state_d = S_CLO;
        else cmd_o.op = fwao_pkg::OP_DIV_STEP;
      end
      S_CLO:  begin cmd_o.op = fwao_pkg::OP_MUL_LO; state_d = S_CHI; end
      S_CHI:  begin cmd_o.op = fwao_pkg::OP_MUL_HI; state_d = S_CCMB; end
      S_CCMB: begin cmd_o.op = fwao_pkg::OP_COMBINE; state_d = S_SLO; end
      S_SLO:  begin cmd_o.op = fwao_pkg::OP_MUL_LO; cmd_o.sel = 1'b1; state_d = S_SHI; end
      S_SHI:  begin cmd_o.op = fwao_pkg::OP_MUL_HI; cmd_o.sel = 1'b1; state_d = S_SCMB; end
      S_SCMB: begin cmd_o.op = fwao_pkg::OP_COMBINE; cmd_o.sel = 1'b1; state_d = S_ACC; end
      S_ACC: begin
        cmd_o.op = fwao_pkg::OP_ACC;
        state_d  = st_i.last ? S_HLOAD : S_IDLE;
      end
      // The load also clears the sums for the next cell.
      S_HLOAD: begin cmd_o.op = fwao_pkg::OP_HLOAD; state_d = S_HNORM; end
      S_HNORM: begin
        if (st_i.norm_h_ok) begin
          cmd_o.op = fwao_pkg::OP_SQA;
          state_d  = S_HSQB;
        end else begin
          cmd_o.op = fwao_pkg::OP_NORM;
        end
      end
      S_HSQA:   begin cmd_o.op = fwao_pkg::OP_SQA; state_d = S_HSQB; end
      S_HSQB:   begin cmd_o.op = fwao_pkg::OP_SQB; state_d = S_HRINIT; end
      S_HRINIT: begin cmd_o.op = fwao_pkg::OP_ROOT_SUM; state_d = S_HROOT; end
      S_HROOT: begin
        if (st_i.cnt_zero) state_d = S_HDINIT;
        else cmd_o.op = fwao_pkg::OP_ROOT_STEP;
      end
      S_HDINIT: begin
        cmd_o.op = fwao_pkg::OP_DIV_HALF;
        state_d  = st_i.root_zero ? S_EMIT : S_HDIV;
      end
      S_HDIV: begin
        if (st_i.cnt_zero) state_d = S_XRINIT;
        else cmd_o.op = fwao_pkg::OP_DIV_STEP;
      end
      S_XRINIT: begin cmd_o.op = fwao_pkg::OP_ROOT_Q; state_d = S_XROOT; end
      S_XROOT: begin
        if (st_i.cnt_zero) state_d = S_XSAVE;
        else cmd_o.op = fwao_pkg::OP_ROOT_STEP;
      end
      S_XSAVE:  begin cmd_o.op = fwao_pkg::OP_SAVE_X; state_d = S_YRINIT; end
      S_YRINIT: begin cmd_o.op = fwao_pkg::OP_ROOT_Q; cmd_o.sel = 1'b1; state_d = S_YROOT; end
      S_YROOT: begin
        if (st_i.cnt_zero) state_d = S_EMIT;
        else cmd_o.op = fwao_pkg::OP_ROOT_STEP;
      end
      S_EMIT: begin
        if (!st_i.out_full) begin
          cmd_o.op = fwao_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
